FILE: design/zbp_pkg.sv
// Shared types and constants for the zero-byte pack encoder.
package zbp_pkg;

	localparam int GROUP_SIZE = 8;
	localparam int SLOT_W     = $clog2(GROUP_SIZE);
	localparam int COUNT_W    = SLOT_W + 1;
	localparam int BANK_COUNT = 2;
	localparam int BANK_W     = $clog2(BANK_COUNT);
	localparam int FIFO_CNT_W = $clog2(BANK_COUNT + 1);

	typedef struct packed {
		logic [7:0] data_byte;
		logic       message_end;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_bitmap;
		logic       group_last;
		logic       packed_end;
	} out_item_t;

	// One closed group waiting for the back end.
	typedef struct packed {
		logic [GROUP_SIZE-1:0] bitmap;
		logic [COUNT_W-1:0]    count;
		logic                  msg_end;
	} group_desc_t;

	// Write into the kept-byte banks.
	typedef struct packed {
		logic              en;
		logic [BANK_W-1:0] bank;
		logic [SLOT_W-1:0] slot;
		logic [7:0]        data;
	} kept_wr_t;

endpackage

FILE: design/zbp_front.sv
// Front end: takes bytes, builds the group bitmap and closes groups.
module zbp_front import zbp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        data_valid,
	output logic        data_ready,
	input  in_item_t    data,
	input  logic        fifo_full,
	output logic        push,
	output group_desc_t push_desc,
	output kept_wr_t    kept_wr
);

	logic [SLOT_W-1:0]     pos_q;
	logic [GROUP_SIZE-1:0] map_q;
	logic [COUNT_W-1:0]    cnt_q;
	logic [BANK_W-1:0]     bank_q;

	logic                  accept;
	logic                  nonzero;
	logic                  close;
	logic [GROUP_SIZE-1:0] map_n;
	logic [COUNT_W-1:0]    cnt_n;

	// the open group always owns a free bank unless both are queued
	assign data_ready = !fifo_full;
	assign accept     = data_valid && data_ready;
	assign nonzero    = (data.data_byte != 8'd0);
	assign close      = (pos_q == SLOT_W'(GROUP_SIZE - 1)) || data.message_end;

	always_comb begin
		map_n = map_q;
		cnt_n = cnt_q;
		if (nonzero) begin
			map_n = map_q | (GROUP_SIZE'(1) << pos_q);
			cnt_n = cnt_q + COUNT_W'(1);
		end
	end

	assign push              = accept && close;
	assign push_desc.bitmap  = map_n;
	assign push_desc.count   = cnt_n;
	assign push_desc.msg_end = data.message_end;

	assign kept_wr.en   = accept && nonzero;
	assign kept_wr.bank = bank_q;
	assign kept_wr.slot = cnt_q[SLOT_W-1:0];
	assign kept_wr.data = data.data_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			map_q  <= '0;
			cnt_q  <= '0;
			bank_q <= '0;
		end else if (accept) begin
			if (close) begin
				pos_q  <= '0;
				map_q  <= '0;
				cnt_q  <= '0;
				bank_q <= bank_q + BANK_W'(1);
			end else begin
				pos_q <= pos_q + SLOT_W'(1);
				map_q <= map_n;
				cnt_q <= cnt_n;
			end
		end
	end

endmodule

FILE: design/zbp_desc_fifo.sv
// Short queue of closed-group descriptors between front and back.
module zbp_desc_fifo import zbp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  group_desc_t       push_desc,
	input  logic              pop,
	output logic              full,
	output logic              head_valid,
	output group_desc_t       head_desc,
	output logic [BANK_W-1:0] head_bank
);

	group_desc_t               entry_q [BANK_COUNT];
	logic [BANK_W-1:0]         wr_ptr_q;
	logic [BANK_W-1:0]         rd_ptr_q;
	logic [FIFO_CNT_W-1:0]     count_q;

	assign full       = (count_q == FIFO_CNT_W'(BANK_COUNT));
	assign head_valid = (count_q != '0);
	assign head_desc  = entry_q[rd_ptr_q];
	// entry n owns kept-byte bank n
	assign head_bank  = rd_ptr_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + BANK_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + BANK_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + FIFO_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - FIFO_CNT_W'(1);
			end
		end
	end

endmodule

FILE: design/zbp_back.sv
// Back end: kept-byte banks and the output sequencer (bitmap, then bytes).
module zbp_back import zbp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  kept_wr_t          kept_wr,
	input  logic              head_valid,
	input  group_desc_t       head_desc,
	input  logic [BANK_W-1:0] head_bank,
	output logic              pop,
	output logic              result_valid,
	input  logic              result_ready,
	output out_item_t         result
);

	localparam int MEM_DEPTH = BANK_COUNT * GROUP_SIZE;

	logic [7:0]         kept_mem [MEM_DEPTH];
	// 0: bitmap next, k: kept byte k-1 next
	logic [COUNT_W-1:0] idx_q;
	logic               out_valid_q;
	out_item_t          out_q;

	logic               advance;
	logic               emit;
	logic               is_bm;
	logic               last;
	logic [SLOT_W-1:0]  slot;

	assign advance = !out_valid_q || result_ready;
	assign emit    = advance && head_valid;
	assign is_bm   = (idx_q == '0);
	assign last    = (idx_q == head_desc.count);
	assign slot    = SLOT_W'(idx_q - COUNT_W'(1));
	assign pop     = emit && last;

	always_ff @(posedge clk) begin
		if (kept_wr.en) begin
			kept_mem[{kept_wr.bank, kept_wr.slot}] <= kept_wr.data;
		end
	end

	// output register doubles as the bank read register
	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.out_byte   <= is_bm ? head_desc.bitmap : kept_mem[{head_bank, slot}];
			out_q.is_bitmap  <= is_bm;
			out_q.group_last <= last;
			out_q.packed_end <= last && head_desc.msg_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= head_valid;
			end
			if (emit) begin
				idx_q <= last ? '0 : idx_q + COUNT_W'(1);
			end
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

FILE: design/zero_byte_pack_encoder.sv
// Zero-byte pack encoder top level.
// Bytes enter on the data channel, one per cycle while a group bank is free;
// two banks hold the kept bytes of the open and closed groups, so the front end
// can fill one group while the back end drains the other. The result channel gives at
// most one byte per cycle: a group with n nonzero bytes gives 1 + n output
// bytes (bitmap first), so a message of all-nonzero bytes gives 9 output bytes
// per 8 input bytes. The bitmap of a closed group passes through the descriptor
// queue and then the output register to the result port. No reset-time clearing
// pass is needed.
module zero_byte_pack_encoder import zbp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      data_valid,
	output logic      data_ready,
	input  in_item_t  data,
	output logic      result_valid,
	input  logic      result_ready,
	output out_item_t result
);

	logic              fifo_full;
	logic              push;
	group_desc_t       push_desc;
	kept_wr_t          kept_wr;
	logic              pop;
	logic              head_valid;
	group_desc_t       head_desc;
	logic [BANK_W-1:0] head_bank;

	zbp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.data_valid (data_valid),
		.data_ready (data_ready),
		.data       (data),
		.fifo_full  (fifo_full),
		.push       (push),
		.push_desc  (push_desc),
		.kept_wr    (kept_wr)
	);

	zbp_desc_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_desc  (push_desc),
		.pop        (pop),
		.full       (fifo_full),
		.head_valid (head_valid),
		.head_desc  (head_desc),
		.head_bank  (head_bank)
	);

	zbp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.kept_wr      (kept_wr),
		.head_valid   (head_valid),
		.head_desc    (head_desc),
		.head_bank    (head_bank),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

FILE: design/zbp_checker.sv
// Port-level checks for the zero-byte pack encoder, bound to the top level.
module zbp_checker import zbp_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      result_valid,
	input logic      result_ready,
	input out_item_t result
);

	logic               expect_bm_q;
	logic [COUNT_W-1:0] data_cnt_q;
	logic               res_accept;

	assign res_accept = result_valid && result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_bm_q <= 1'b1;
			data_cnt_q  <= '0;
		end else if (res_accept) begin
			expect_bm_q <= result.group_last;
			if (result.is_bitmap || result.group_last) begin
				data_cnt_q <= '0;
			end else begin
				data_cnt_q <= data_cnt_q + COUNT_W'(1);
			end
		end
	end

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	a_bitmap_first: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && expect_bm_q |-> result.is_bitmap)
		else $error("group does not open with its bitmap");

	a_one_bitmap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !expect_bm_q |-> !result.is_bitmap)
		else $error("bitmap inside an open group");

	a_end_closes_group: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.packed_end |-> result.group_last)
		else $error("message end without group end");

	a_group_size: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.is_bitmap |-> data_cnt_q < COUNT_W'(GROUP_SIZE))
		else $error("more than eight kept bytes in a group");

endmodule

bind zero_byte_pack_encoder zbp_checker u_zbp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

FILE: tb/sv/testbench.sv
// Self-checking testbench for the zero-byte pack encoder: directed, random, backpressure and full-rate runs.
module testbench;
	import zbp_pkg::*;

	logic      clk;
	logic      arst_n;
	logic      data_valid;
	logic      data_ready;
	in_item_t  data;
	logic      result_valid;
	logic      result_ready;
	out_item_t result;

	zero_byte_pack_encoder i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.data_valid   (data_valid),
		.data_ready   (data_ready),
		.data         (data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	// Packing model state
	logic [7:0] kept_model [GROUP_SIZE];
	logic [7:0] map_model;
	logic [2:0] pos_model;
	logic [3:0] cnt_model;

	out_item_t expected_bytes [$];

	int  mismatch_count = 0;
	int  result_count   = 0;
	int  byte_count     = 0;
	int  message_count  = 0;
	int  group_count    = 0;
	int  input_stalls   = 0;
	bit  idle_on        = 1'b1;
	bit  sender_idle    = 1'b1;
	int  hold_len       = 0;
	int  stall_left     = 0;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic report_mismatch(string field, logic [7:0] got, logic [7:0] want);
		mismatch_count++;
		$display("MISMATCH at output byte %0d, %s: got 0x%02h, expected 0x%02h",
			result_count, field, got, want);
	endtask

	// Update the model with one accepted byte; on group close queue the packed bytes.
	task automatic pack_predict(in_item_t it);
		logic [2:0] pos;
		bit         full;
		int         n;
		bit         last;
		pos  = pos_model;
		full = (pos == 3'd7);
		if (it.data_byte != 8'h00) begin
			map_model[pos] = 1'b1;
			if (cnt_model < 4'(GROUP_SIZE)) begin
				kept_model[cnt_model[2:0]] = it.data_byte;
				cnt_model = cnt_model + 4'd1;
			end
		end
		pos_model = pos + 3'd1;
		if (!full && !it.message_end)
			return;
		n = int'(cnt_model);
		expected_bytes.push_back(out_item_t'{map_model, 1'b1, n == 0,
			it.message_end && n == 0});
		for (int k = 0; k < n; k++) begin
			last = (k + 1 == n);
			expected_bytes.push_back(out_item_t'{kept_model[k], 1'b0, last,
				it.message_end && last});
		end
		group_count++;
		if (it.message_end)
			message_count++;
		map_model = 8'h00;
		pos_model = 3'd0;
		cnt_model = 4'd0;
	endtask

	// Offer one byte, optionally after an idle burst, and hold it until accepted.
	task automatic send_byte(logic [7:0] b, logic last);
		int gap;
		gap = (idle_on && sender_idle && $urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
		@(negedge clk);
		if (gap > 0) begin
			data_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		data_valid <= 1'b1;
		data       <= in_item_t'{b, last};
		@(posedge clk);
		while (!data_ready) begin
			input_stalls++;
			@(posedge clk);
		end
		byte_count++;
		pack_predict(in_item_t'{b, last});
	endtask

	function automatic logic [7:0] rand_byte();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return 8'h00;
		else if (r < 5)
			return 8'hff;
		else
			return 8'($urandom_range(0, 255));
	endfunction

	task automatic send_message(int len);
		for (int i = 0; i < len; i++)
			send_byte(rand_byte(), i == len - 1);
	endtask

	task automatic test_directed();
		logic [7:0] mixed [3];
		mixed = '{8'h01, 8'h00, 8'h80};
		// lone zero byte ending a message: bitmap only, with packed_end
		send_byte(8'h00, 1'b1);
		send_byte(8'hff, 1'b1);
		// all-zero group closed mid-message, then a full group at message end
		for (int i = 0; i < 8; i++)
			send_byte(8'h00, 1'b0);
		for (int i = 0; i < 8; i++)
			send_byte(8'hff, i == 7);
		// short final group with a hole
		for (int i = 0; i < 3; i++)
			send_byte(mixed[i], i == 2);
	endtask

	task automatic test_random();
		int start;
		int len;
		start = byte_count;
		while (byte_count - start < 340) begin
			case ($urandom_range(0, 9))
				0, 1:    len = 8 * $urandom_range(1, 4);
				2:       len = 1;
				3:       len = $urandom_range(25, 40);
				default: len = $urandom_range(2, 24);
			endcase
			send_message(len);
		end
	endtask

	// Receiver holds off while the sender keeps offering, so the banks fill up.
	task automatic test_pressure();
		sender_idle = 1'b0;
		hold_len    = 300;
		for (int i = 0; i < 48; i++)
			send_byte(8'($urandom_range(1, 255)), i == 47);
		sender_idle = 1'b1;
	endtask

	task automatic test_full_rate();
		idle_on = 1'b0;
		for (int i = 0; i < 40; i++)
			send_byte(($urandom_range(0, 4) == 0) ? 8'h00 : 8'($urandom_range(1, 255)),
				i == 39);
	endtask

	// Result side flow control
	initial begin : result_flow
		result_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				result_ready <= 1'b0;
				stall_left--;
			end else if (hold_len > 0) begin
				result_ready <= 1'b0;
				stall_left = hold_len - 1;
				hold_len   = 0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				result_ready <= 1'b0;
				stall_left = $urandom_range(1, 11) - 1;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	initial begin : result_check
		out_item_t want;
		forever begin
			@(posedge clk);
			if (result_valid && result_ready) begin
				if (expected_bytes.size() == 0) begin
					report_mismatch("unexpected transaction", result.out_byte, 8'h00);
				end else begin
					want = expected_bytes.pop_front();
					if (result.out_byte !== want.out_byte)
						report_mismatch("out_byte", result.out_byte, want.out_byte);
					if (result.is_bitmap !== want.is_bitmap)
						report_mismatch("is_bitmap", 8'(result.is_bitmap), 8'(want.is_bitmap));
					if (result.group_last !== want.group_last)
						report_mismatch("group_last", 8'(result.group_last),
							8'(want.group_last));
					if (result.packed_end !== want.packed_end)
						report_mismatch("packed_end", 8'(result.packed_end),
							8'(want.packed_end));
				end
				result_count++;
			end
		end
	end

	initial begin : watchdog
		#5000000;
		$display("zero_byte_pack_encoder test failed");
		$finish;
	end

	initial begin : main
		arst_n     = 1'b0;
		data_valid = 1'b0;
		data       = '0;
		map_model  = 8'h00;
		pos_model  = 3'd0;
		cnt_model  = 4'd0;
		for (int i = 0; i < GROUP_SIZE; i++)
			kept_model[i] = 8'h00;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random();
		test_pressure();
		test_full_rate();

		@(negedge clk);
		data_valid <= 1'b0;
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (expected_bytes.size() != 0)
			report_mismatch("missing transactions", 8'(expected_bytes.size()), 8'h00);

		$display("Sent %0d bytes in %0d messages, %0d groups; checked %0d output bytes.",
			byte_count, message_count, group_count, result_count);
		$display("Input was held off for %0d cycles; %0d mismatches.",
			input_stalls, mismatch_count);
		if (mismatch_count == 0)
			$display("zero_byte_pack_encoder test passed");
		else
			$display("zero_byte_pack_encoder test failed");
		$finish;
	end

endmodule

FILE: files.f
design/zbp_pkg.sv
design/zbp_front.sv
design/zbp_desc_fifo.sv
design/zbp_back.sv
design/zero_byte_pack_encoder.sv
design/zbp_checker.sv
tb/sv/testbench.sv
